/* rtl/npfg_pkg.sv */
// Shared types and constants for the NoC packet flit generator.
// Used by the controller, the datapath and the top level; no dependencies.
package npfg_pkg;

   localparam int DEF_MAX_PACKETS = 16;
   localparam int DEF_NUM_VCS     = 4;

   localparam logic [2:0] STATUS_OK     = 3'd0;
   localparam logic [2:0] STATUS_FULL   = 3'd1;
   localparam logic [2:0] STATUS_BAD_VC = 3'd2;
   localparam logic [2:0] STATUS_ZERO   = 3'd3;
   localparam logic [2:0] STATUS_EMPTY  = 3'd4;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_SEND = 1'b1;

   typedef struct packed {
      logic       mode;
      logic [7:0] packet_dest;
      logic [7:0] packet_flits;
      logic [2:0] packet_vc;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  flit_dest;
      logic [2:0]  flit_vc;
      logic        head_flag;
      logic        tail_flag;
      logic [31:0] flit_seq;
      logic        finished;
   } rsp_type;

   typedef struct packed {
      logic [7:0] dest;
      logic [7:0] flits;
      logic [2:0] vc;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_cmd_type;

endpackage

/* rtl/npfg_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
module npfg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/npfg_ctrl.sv */
// Controller for the NoC packet flit generator: two-state sequencer and
// result strobe. Depends on npfg_pkg for the command struct.
module npfg_ctrl
   import npfg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output ctrl_cmd_type cmd,
   output logic         rsp_strobe
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           strobe_ff, strobe_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign strobe_in   = (state_ff == ST_EXEC);
   assign busy        = (state_ff != ST_IDLE);
   assign cmd.capture = start && (state_ff == ST_IDLE);
   assign cmd.execute = (state_ff == ST_EXEC);
   assign rsp_strobe  = strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

endmodule

/* rtl/npfg_datapath.sv */
// Datapath for the NoC packet flit generator: packet table, counters and
// result register. Depends on npfg_pkg and npfg_ram.
module npfg_datapath
   import npfg_pkg::*;
#(
   parameter int MAX_PACKETS = DEF_MAX_PACKETS,
   parameter int NUM_VCS     = DEF_NUM_VCS
) (
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type cmd,
   input  req_type      req_data,
   input  logic         csr_write,
   input  logic [15:0]  csr_wdata,
   output rsp_type      rsp_data
);

   localparam int IDX_W = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
   localparam int CNT_W = $clog2(MAX_PACKETS + 1);
   localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_PACKETS);
   localparam logic [3:0] VC_LIMIT = 4'(NUM_VCS);

   req_type          req_ff;
   rsp_type          rsp_ff, rsp_in;
   logic [15:0]      total_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [7:0]       left_ff, left_in;
   logic [15:0]      sent_ff, sent_in;
   logic [31:0]      seq_ff, seq_in;

   entry_type        rd_entry, wr_entry;
   logic             wr_en;
   logic [7:0]       cur_flits;
   logic [7:0]       left_after;
   logic             first_flit;

   npfg_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_PACKETS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_entry),
      .rd_addr (head_ff),
      .rd_data (rd_entry)
   );

   assign wr_entry.dest  = req_ff.packet_dest;
   assign wr_entry.flits = req_ff.packet_flits;
   assign wr_entry.vc    = req_ff.packet_vc;

   // The head index stays below the entry count whenever the table is not
   // empty, so the table read needs no wrap of its own; the RAM read was issued while idle.
   assign first_flit = (left_ff == 8'd0);
   assign cur_flits  = first_flit ? rd_entry.flits : left_ff;
   assign left_after = cur_flits - 8'd1;

   always_comb begin
      rsp_in   = '0;
      wr_en    = 1'b0;
      count_in = count_ff;
      head_in  = head_ff;
      left_in  = left_ff;
      sent_in  = sent_ff;
      seq_in   = seq_ff;
      if (req_ff.mode == MODE_LOAD) begin
         priority if (count_ff == COUNT_MAX) begin
            rsp_in.status = STATUS_FULL;
         end else if ({1'b0, req_ff.packet_vc} >= VC_LIMIT) begin
            rsp_in.status = STATUS_BAD_VC;
         end else if (req_ff.packet_flits == 8'd0) begin
            rsp_in.status = STATUS_ZERO;
         end else begin
            rsp_in.status = STATUS_OK;
            wr_en         = cmd.execute;
            count_in      = count_ff + CNT_W'(1);
         end
      end else if (count_ff == '0) begin
         rsp_in.status = STATUS_EMPTY;
      end else begin
         rsp_in.status    = STATUS_OK;
         rsp_in.flit_dest = rd_entry.dest;
         rsp_in.flit_vc   = rd_entry.vc;
         rsp_in.head_flag = first_flit;
         rsp_in.tail_flag = (cur_flits == 8'd1);
         rsp_in.flit_seq  = seq_ff;
         seq_in           = seq_ff + 32'd1;
         left_in          = left_after;
         if (left_after == 8'd0) begin
            head_in = (CNT_W'(head_ff) == count_ff - CNT_W'(1)) ? '0 : head_ff + IDX_W'(1);
            if (sent_ff != '1) sent_in = sent_ff + 16'd1;
         end
      end
      rsp_in.finished = (sent_in >= total_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      if (cmd.execute) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         count_ff <= '0;
         head_ff  <= '0;
         left_ff  <= '0;
         sent_ff  <= '0;
         seq_ff   <= '0;
      end else begin
         if (csr_write) total_ff <= csr_wdata;
         if (cmd.execute) begin
            count_ff <= count_in;
            head_ff  <= head_in;
            left_ff  <= left_in;
            sent_ff  <= sent_in;
            seq_ff   <= seq_in;
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

/* rtl/noc_packet_flit_generator.sv */
// Channel   Handshake            Payload
// req       start / busy         req_data (req_type)
// rsp       rsp_strobe           rsp_data (rsp_type)
// csr       csr_write            csr_wdata (total packets, 16 bits)
//
// Each transaction has an accept cycle, in which the table RAM is read at
// the head index, and an execute cycle on the registered read data. The
// result strobe comes in the cycle after execute, while the next
// transaction may already be accepted. busy is high during execute.
// Reset is synchronous and clears all counters; the table is not cleared.
// The receiver cannot stall results.
module noc_packet_flit_generator
   import npfg_pkg::*;
#(
   parameter int MAX_PACKETS = DEF_MAX_PACKETS,
   parameter int NUM_VCS     = DEF_NUM_VCS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [15:0] csr_wdata
);

   ctrl_cmd_type cmd;

   npfg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe)
   );

   npfg_datapath #(
      .MAX_PACKETS (MAX_PACKETS),
      .NUM_VCS     (NUM_VCS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

   // Every accepted transaction yields a result strobe, registered after its execute state.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("result strobe missing after accepted transaction");

   // A result never appears while a transaction is in execution.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe during execute");

   // Results are single-cycle and never back to back.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   // A head or tail flit is only ever reported with an ok status.
   a_flags_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.head_flag || rsp_data.tail_flag))
         |-> (rsp_data.status == STATUS_OK))
      else $error("flit flags set on a failed transaction");

endmodule
